// File: hw/rtl/lgs_pkg.sv
// Shared types, constants and helper functions for the life grid generation step block.
package lgs_pkg;

    // Field and port widths fixed by the stream format.
    localparam int SIZE_W     = 7;
    localparam int ROW_IDX_W  = 6;
    localparam int ROW_BITS_W = 64;
    localparam int TDATA_W    = 72;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int NBR_W      = 4;

    // Smallest grid side in use, and the neighbour counts of the rule.
    localparam logic [SIZE_W-1:0] MIN_SIZE      = 7'd3;
    localparam logic [NBR_W-1:0]  BIRTH_COUNT   = 4'd3;
    localparam logic [NBR_W-1:0]  SURVIVE_COUNT = 4'd2;

    // Register reset values.
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 7'd64;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 7'd40;
    localparam logic              WRAP_RESET   = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_STEP  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_WRAP   = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME_TOP,
        ST_PRIME_BOTTOM,
        ST_RUN
    } state_t;

    // Settings that the rule unit needs for one row.
    typedef struct packed {
        logic              wrap;
        logic [SIZE_W-1:0] used_width;
    } rule_cfg_t;

    // Saturate a configured side length to the range in use.
    function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] value,
                                                   input logic [SIZE_W-1:0] max_value);
        logic [SIZE_W-1:0] result;
        result = value;
        if (value < MIN_SIZE)
        begin
            result = MIN_SIZE;
        end
        else if (value > max_value)
        begin
            result = max_value;
        end
        return result;
    endfunction

    // One bit set for every column below the width in use.
    function automatic logic [ROW_BITS_W-1:0] col_mask(input logic [SIZE_W-1:0] width);
        logic [ROW_BITS_W-1:0] mask;
        for (int c = 0; c < ROW_BITS_W; c++)
        begin
            mask[c] = (SIZE_W'(c) < width);
        end
        return mask;
    endfunction

endpackage

// File: hw/rtl/lgs_row_mem.sv
// Row store of the cell grid: one write port, one registered read port, per-row valid bits.
module lgs_row_mem
    import lgs_pkg::*;
#(
    parameter int ROWS = 64,
    parameter int COLS = 64,
    parameter int AW   = 6
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clr,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  logic [COLS-1:0] wr_data,
    input  logic [AW-1:0]   rd_addr,
    output logic [COLS-1:0] rd_data
);

    logic [COLS-1:0] mem [ROWS];
    logic [COLS-1:0] rd_data_reg;
    logic            rd_valid_reg;
    logic [ROWS-1:0] valid_reg;

    // Storage array and its registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // A row that has never been written since reset or a clear reads as dead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: hw/rtl/lgs_rule.sv
// Next-generation rule for one row from the rows above, at and below it.
module lgs_rule
    import lgs_pkg::*;
#(
    parameter int COLS = 64
)
(
    input  rule_cfg_t       cfg,
    input  logic [COLS-1:0] up_row,
    input  logic [COLS-1:0] mid_row,
    input  logic [COLS-1:0] down_row,
    output logic [COLS-1:0] next_row
);

    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

    logic [ROW_BITS_W-1:0] full_mask;
    logic [COLS-1:0]       mask;
    logic [SIZE_W-1:0]     last_col_wide;
    logic [CW-1:0]         last_col;
    logic [COLS-1:0]       rows [3];
    logic [COLS-1:0]       lft  [3];
    logic [COLS-1:0]       rgt  [3];

    // Neighbour columns of each row, with the wrap bit brought in at either edge.
    always_comb
    begin
        full_mask     = col_mask(cfg.used_width);
        mask          = full_mask[COLS-1:0];
        last_col_wide = cfg.used_width - 7'd1;
        last_col      = last_col_wide[CW-1:0];
        rows[0]       = up_row & mask;
        rows[1]       = mid_row & mask;
        rows[2]       = down_row & mask;
        for (int k = 0; k < 3; k++)
        begin
            lft[k]           = {rows[k][COLS-2:0], 1'b0};
            lft[k][0]        = cfg.wrap & rows[k][last_col];
            rgt[k]           = {1'b0, rows[k][COLS-1:1]};
            rgt[k][last_col] = rgt[k][last_col] | (cfg.wrap & rows[k][0]);
        end
    end

    // Count the eight neighbours of every column and apply birth on three, survival on two.
    always_comb
    begin
        logic [NBR_W-1:0] n;
        n = '0;
        for (int c = 0; c < COLS; c++)
        begin
            n = {3'b000, lft[0][c]} + {3'b000, rows[0][c]} + {3'b000, rgt[0][c]}
              + {3'b000, lft[1][c]} + {3'b000, rgt[1][c]}
              + {3'b000, lft[2][c]} + {3'b000, rows[2][c]} + {3'b000, rgt[2][c]};
            next_row[c] = mask[c] & ((n == BIRTH_COUNT) ||
                                     (rows[1][c] && (n == SURVIVE_COUNT)));
        end
    end

endmodule

// File: hw/rtl/life_grid_generation_step.sv
// Top level of the life grid generation step: configuration, sequencer and output register.
// A load or clear transaction is handled in the idle state; a clear empties the grid at once.
// A step fetches the edge rows in ST_PRIME_TOP and ST_PRIME_BOTTOM, then in ST_RUN writes
// back and emits one row per cycle while the output register is free to take it.
// Rows pass through the one write port and the registered read port of the row store.
// After reset every cell reads dead through per-row valid bits; there is no clearing pass.
module life_grid_generation_step
    import lgs_pkg::*;
#(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: row_index (6), row_bits (64), zero fill (2).
    input  logic [TDATA_W-1:0]   s_axis_tdata,
    // Fields from bit 0: req_type (2).
    input  logic [KIND_W-1:0]    s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0: out_row_index (6), out_row_bits (64), zero fill (2).
    output logic [TDATA_W-1:0]   m_axis_tdata,
    output logic                 m_axis_tlast
);

    localparam int COLS = MAX_COLUMNS;
    localparam int AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    state_t                state_reg, state_next;
    logic [SIZE_W-1:0]     width_reg, height_reg;
    logic                  wrap_reg;
    logic [SIZE_W-1:0]     row_reg, row_next;
    logic [COLS-1:0]       first_reg, prev_reg, cur_reg;
    logic [TDATA_W-1:0]    m_tdata_reg;
    logic                  m_tvalid_reg, m_tlast_reg;

    logic [SIZE_W-1:0]     used_w, used_h, last_row_idx;
    logic [ROW_BITS_W-1:0] full_mask;
    logic [COLS-1:0]       mask;
    rule_cfg_t             rule_cfg;
    logic                  in_fire, fire, at_last;
    req_kind_t             in_kind;
    logic [ROW_IDX_W-1:0]  in_idx;
    logic [COLS-1:0]       in_bits;
    logic [COLS-1:0]       rd_row, below_row, new_row;
    logic                  mem_clr, mem_wr_en;
    logic [SIZE_W-1:0]     wr_addr_wide, rd_addr_wide;
    logic [COLS-1:0]       wr_data;
    logic [TDATA_W-1:0]    out_pack;

    // Sizes in use and the column mask.
    always_comb
    begin
        used_w              = sat_size(width_reg, SIZE_W'(MAX_COLUMNS));
        used_h              = sat_size(height_reg, SIZE_W'(MAX_ROWS));
        last_row_idx        = used_h - 7'd1;
        full_mask           = col_mask(used_w);
        mask                = full_mask[COLS-1:0];
        rule_cfg.wrap       = wrap_reg;
        rule_cfg.used_width = used_w;
    end

    // Configuration registers; a write beyond the register list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            wrap_reg   <= WRAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_WRAP:   wrap_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Input unpacking and handshake.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_kind       = req_kind_t'(s_axis_tuser);
    assign in_idx        = s_axis_tdata[ROW_IDX_W-1:0];
    assign in_bits       = s_axis_tdata[ROW_IDX_W +: COLS];

    // A row is computed whenever the output register is free to take it.
    assign fire      = (state_reg == ST_RUN) && (!m_tvalid_reg || m_axis_tready);
    assign at_last   = (row_reg == last_row_idx);
    assign below_row = at_last ? (wrap_reg ? first_reg : '0) : (rd_row & mask);

    lgs_rule #(
        .COLS (COLS)
    ) u_rule (
        .cfg      (rule_cfg),
        .up_row   (prev_reg),
        .mid_row  (cur_reg),
        .down_row (below_row),
        .next_row (new_row)
    );

    // Sequencer: next state, row counter and row store accesses.
    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        mem_clr      = 1'b0;
        mem_wr_en    = 1'b0;
        wr_addr_wide = row_reg;
        wr_data      = new_row;
        rd_addr_wide = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_kind)
                        REQ_LOAD:
                        begin
                            mem_wr_en    = ({1'b0, in_idx} < used_h);
                            wr_addr_wide = {1'b0, in_idx};
                            wr_data      = in_bits & mask;
                        end
                        REQ_STEP:  state_next = ST_PRIME_TOP;
                        REQ_CLEAR: mem_clr    = 1'b1;
                        default:   ;
                    endcase
                end
            end
            ST_PRIME_TOP:
            begin
                rd_addr_wide = last_row_idx;
                state_next   = ST_PRIME_BOTTOM;
            end
            ST_PRIME_BOTTOM:
            begin
                rd_addr_wide = 7'd1;
                row_next     = '0;
                state_next   = ST_RUN;
            end
            ST_RUN:
            begin
                mem_wr_en    = fire;
                rd_addr_wide = (fire && !at_last && (row_reg + 7'd1 != last_row_idx))
                             ? row_reg + 7'd2 : row_reg + 7'd1;
                if (fire)
                begin
                    if (at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 7'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    lgs_row_mem #(
        .ROWS (MAX_ROWS),
        .COLS (COLS),
        .AW   (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (mem_clr),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_addr_wide[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr_wide[AW-1:0]),
        .rd_data (rd_row)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    // Row window: saved top row, the row above and the row being computed.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PRIME_TOP)
        begin
            first_reg <= rd_row & mask;
            cur_reg   <= rd_row & mask;
        end
        else if (state_reg == ST_PRIME_BOTTOM)
        begin
            prev_reg <= wrap_reg ? (rd_row & mask) : '0;
        end
        else if (fire)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= below_row;
        end
    end

    // Output register packing.
    always_comb
    begin
        out_pack                  = '0;
        out_pack[ROW_IDX_W-1:0]   = row_reg[ROW_IDX_W-1:0];
        out_pack[ROW_IDX_W +: COLS] = new_row;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            m_tdata_reg <= out_pack;
            m_tlast_reg <= at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (fire)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tlast  = m_tlast_reg;

    // The write-back of a row never lands on the row being fetched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && mem_wr_en) |-> (rd_addr_wide != wr_addr_wide))
    else $error("row store write and read collide during a step");

    // The row counter stays inside the grid while rows are emitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (row_reg <= last_row_idx))
    else $error("row counter beyond the grid height");

    // The flagged row of a run is the bottom row in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast)
            |-> (m_axis_tdata[ROW_IDX_W-1:0] == last_row_idx[ROW_IDX_W-1:0]))
    else $error("last flag on a row other than the bottom row");

    // Emitting the bottom row ends the step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && at_last) |=> (state_reg == ST_IDLE))
    else $error("sequencer did not return to idle after the bottom row");

endmodule

// File: bench/life_grid_generation_step_checker.sv
// Row checker for the life grid generation step: tracks the grid and compares every emitted row.
module life_grid_generation_step_checker
    import lgs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // Fields from bit 0: row_index (6), row_bits (64), zero fill (2).
    input  logic [TDATA_W-1:0]   s_axis_tdata,
    // Fields from bit 0: req_type (2).
    input  logic [KIND_W-1:0]    s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0: out_row_index (6), out_row_bits (64), zero fill (2).
    input  logic [TDATA_W-1:0]   m_axis_tdata,
    input  logic                 m_axis_tlast,
    output int                   mismatches,
    output int                   rows_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_ROWS          = 64;
    localparam int GRID_COLS          = 64;
    localparam int MIN_SIDE           = 3;
    localparam int BIRTH_NEIGHBOURS   = 3;
    localparam int SURVIVE_NEIGHBOURS = 2;

    localparam logic [SIZE_W-1:0] WIDTH_AT_RESET  = 7'd64;
    localparam logic [SIZE_W-1:0] HEIGHT_AT_RESET = 7'd40;
    localparam logic              WRAP_AT_RESET   = 1'b1;

    // One emitted row of a generation.
    typedef struct packed {
        logic [ROW_IDX_W-1:0]  row_num;
        logic [ROW_BITS_W-1:0] cells;
        logic                  is_last;
    } gen_row_t;

    gen_row_t              expected_rows[$];
    logic [ROW_BITS_W-1:0] grid_rows[GRID_ROWS];
    logic [SIZE_W-1:0]     width_reg;
    logic [SIZE_W-1:0]     height_reg;
    logic                  wrap_reg;

    // Next state of the middle row from its neighbours above and below, B3/S23 rule.
    function automatic logic [ROW_BITS_W-1:0] next_generation_row(
        input logic [ROW_BITS_W-1:0] up,
        input logic [ROW_BITS_W-1:0] mid,
        input logic [ROW_BITS_W-1:0] down,
        input int                    w,
        input logic                  wrap);
        logic [ROW_BITS_W-1:0] born;
        int                    live;
        int                    col;
        born = '0;
        for (int c = 0; c < w; c++)
        begin
            live = 0;
            for (int d = -1; d <= 1; d++)
            begin
                col = c + d;
                // Off the edge either wraps round or counts as a dead cell.
                if (col < 0)
                begin
                    col = wrap ? w - 1 : -1;
                end
                else if (col >= w)
                begin
                    col = wrap ? 0 : -1;
                end
                if (col >= 0)
                begin
                    live += int'(up[col]) + int'(down[col]);
                    if (d != 0)
                    begin
                        live += int'(mid[col]);
                    end
                end
            end
            born[c] = (live == BIRTH_NEIGHBOURS) || (mid[c] && live == SURVIVE_NEIGHBOURS);
        end
        return born;
    endfunction

    // Follow the configuration and input transactions, and check each output transaction.
    always @(posedge clk or negedge rst_n)
    begin
        int                    w;
        int                    h;
        logic [ROW_BITS_W-1:0] mask;
        logic [ROW_BITS_W-1:0] top_copy;
        logic [ROW_BITS_W-1:0] above;
        logic [ROW_BITS_W-1:0] cur;
        logic [ROW_BITS_W-1:0] below;
        logic [ROW_BITS_W-1:0] nr;
        logic [ROW_IDX_W-1:0]  load_row;
        gen_row_t              row_entry;
        gen_row_t              seen;

        if (!rst_n)
        begin
            for (int r = 0; r < GRID_ROWS; r++)
            begin
                grid_rows[r] = '0;
            end
            width_reg  = WIDTH_AT_RESET;
            height_reg = HEIGHT_AT_RESET;
            wrap_reg   = WRAP_AT_RESET;
            expected_rows.delete();
            mismatches   = 0;
            rows_pending = 0;
        end
        else
        begin
            // Register writes.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  = cfg_data;
                    CFG_HEIGHT: height_reg = cfg_data;
                    CFG_WRAP:   wrap_reg   = cfg_data[0];
                    default:    ;
                endcase
            end

            // Sizes in use are saturated to the supported range.
            w = int'(width_reg);
            if (w < MIN_SIDE)
            begin
                w = MIN_SIDE;
            end
            else if (w > GRID_COLS)
            begin
                w = GRID_COLS;
            end
            h = int'(height_reg);
            if (h < MIN_SIDE)
            begin
                h = MIN_SIDE;
            end
            else if (h > GRID_ROWS)
            begin
                h = GRID_ROWS;
            end
            mask = (w >= GRID_COLS) ? '1 : ((64'd1 << w) - 64'd1);

            // Requests update the grid; a step queues every row in use.
            if (s_axis_tvalid && s_axis_tready)
            begin
                load_row = s_axis_tdata[ROW_IDX_W-1:0];
                case (s_axis_tuser)
                    REQ_LOAD:
                    begin
                        if (int'(load_row) < h)
                        begin
                            grid_rows[load_row] = s_axis_tdata[ROW_IDX_W +: ROW_BITS_W] & mask;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        for (int r = 0; r < GRID_ROWS; r++)
                        begin
                            grid_rows[r] = '0;
                        end
                    end
                    REQ_STEP:
                    begin
                        top_copy = grid_rows[0] & mask;
                        above    = wrap_reg ? (grid_rows[h-1] & mask) : '0;
                        for (int r = 0; r < h; r++)
                        begin
                            cur = grid_rows[r] & mask;
                            if (r < h - 1)
                            begin
                                below = grid_rows[r+1] & mask;
                            end
                            else
                            begin
                                below = wrap_reg ? top_copy : '0;
                            end
                            nr = next_generation_row(above, cur, below, w, wrap_reg) & mask;
                            grid_rows[r] = nr;
                            above = cur;
                            row_entry.row_num = ROW_IDX_W'(r);
                            row_entry.cells   = nr;
                            row_entry.is_last = (r == h - 1);
                            expected_rows.push_back(row_entry);
                        end
                    end
                    default:
                    begin
                        // The unused request kind leaves everything as it was.
                    end
                endcase
            end

            // Compare an accepted output row with the oldest one expected.
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.row_num = m_axis_tdata[ROW_IDX_W-1:0];
                seen.cells   = m_axis_tdata[ROW_IDX_W +: ROW_BITS_W];
                seen.is_last = m_axis_tlast;
                if (expected_rows.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected row, expected none, got row %0d cells %h last %b",
                             $time, seen.row_num, seen.cells, seen.is_last);
                end
                else
                begin
                    row_entry = expected_rows.pop_front();
                    if (seen.row_num !== row_entry.row_num)
                    begin
                        mismatches++;
                        $display("%0t: row index expected %0d, got %0d",
                                 $time, row_entry.row_num, seen.row_num);
                    end
                    if (seen.cells !== row_entry.cells)
                    begin
                        mismatches++;
                        $display("%0t: row %0d cells expected %h, got %h",
                                 $time, row_entry.row_num, row_entry.cells, seen.cells);
                    end
                    if (seen.is_last !== row_entry.is_last)
                    begin
                        mismatches++;
                        $display("%0t: row %0d last flag expected %b, got %b",
                                 $time, row_entry.row_num, row_entry.is_last, seen.is_last);
                    end
                end
            end
            rows_pending = expected_rows.size();
        end
    end

endmodule

// File: bench/life_grid_generation_step_tb.sv
// Testbench top for the life grid generation step: clock, reset, stimulus and verdict.
module life_grid_generation_step_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lgs_pkg::*;

    localparam int RANDOM_ITEMS   = 295;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 80;
    localparam int MIN_SIDE       = 3;
    localparam int GRID_ROWS      = 64;

    // Request kind that the block does not use.
    localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_WIDTH;
    logic [SIZE_W-1:0]    cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [KIND_W-1:0]    s_axis_tuser  = REQ_LOAD;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic                 m_axis_tlast;

    int   mismatches;
    int   rows_pending;
    int   quiet_cycles  = 0;
    int   idle_level    = 1;
    int   used_height   = 40;
    int   hold_requests = 0;

    always #5 clk = ~clk;

    life_grid_generation_step uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    life_grid_generation_step_checker row_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .rows_pending  (rows_pending)
    );

    // Idle length: mostly none or short, now and then long; none at all in eager stretches.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (idle_level == 0 || roll < 55)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Row contents of assorted densities.
    function automatic logic [ROW_BITS_W-1:0] random_cells();
        logic [ROW_BITS_W-1:0] a;
        logic [ROW_BITS_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0:       return '1;
            1:       return '0;
            2:       return a & b;
            3:       return a | b;
            4:       return a & b & {$urandom, $urandom};
            5:       return 64'd1 << $urandom_range(0, 63);
            default: return a;
        endcase
    endfunction

    // Offer one request and hold it until the block takes the transaction.
    task automatic send_request(input logic [KIND_W-1:0]     kind,
                                input logic [ROW_IDX_W-1:0]  row,
                                input logic [ROW_BITS_W-1:0] cells);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, cells, row};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Stop offering and let every expected row come out, then let the block settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (rows_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all three registers on consecutive cycles.
    task automatic configure(input logic [SIZE_W-1:0] width,
                             input logic [SIZE_W-1:0] height,
                             input logic              wrap);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= width;
        @(negedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= height;
        @(negedge clk);
        cfg_index <= CFG_WRAP;
        cfg_data  <= {{(SIZE_W-1){1'b0}}, wrap};
        @(negedge clk);
        cfg_we <= 1'b0;
        used_height = (int'(height) < MIN_SIDE) ? MIN_SIDE :
                      (int'(height) > GRID_ROWS) ? GRID_ROWS : int'(height);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        int gap;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests > holds_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                holds_done++;
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    stall_left = gap - 1;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("life_grid_generation_step: mismatch");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [KIND_W-1:0]    kind;
        logic [ROW_IDX_W-1:0] row;
        logic [SIZE_W-1:0]    width;
        logic [SIZE_W-1:0]    height;
        int                   useful_items;

        useful_items = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: empty grid, full-width edges, rows past the height, unused kind.
        send_request(REQ_STEP, '0, '0);
        send_request(REQ_LOAD, 6'd0, '1);
        send_request(REQ_LOAD, 6'd1, 64'h8000_0000_0000_0001);
        send_request(REQ_LOAD, 6'd39, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(REQ_LOAD, 6'd63, '1);
        send_request(REQ_UNUSED, 6'd63, '1);
        send_request(REQ_STEP, '0, '0);
        send_request(REQ_STEP, '0, '0);
        send_request(REQ_CLEAR, '0, '0);
        send_request(REQ_STEP, '0, '0);

        // Width below range and height above range saturate; dead edges.
        wait_idle();
        configure(7'd0, 7'd127, 1'b0);
        send_request(REQ_LOAD, 6'd63, '1);
        send_request(REQ_LOAD, 6'd0, 64'h5);
        send_request(REQ_LOAD, 6'd1, 64'h7);
        send_request(REQ_STEP, '0, '0);
        send_request(REQ_STEP, '0, '0);

        // Width above range and height below range saturate; wrapped edges.
        wait_idle();
        configure(7'd127, 7'd2, 1'b1);
        send_request(REQ_LOAD, 6'd2, '1);
        send_request(REQ_LOAD, 6'd1, 64'h8000_0007_0000_0001);
        send_request(REQ_LOAD, 6'd3, '1);
        send_request(REQ_STEP, '0, '0);

        // A blinker on a narrow grid.
        wait_idle();
        configure(7'd5, 7'd64, 1'b0);
        send_request(REQ_LOAD, 6'd10, 64'h0E);
        send_request(REQ_STEP, '0, '0);
        send_request(REQ_STEP, '0, '0);

        // Largest grid while the receiver holds off, so the block backs up.
        wait_idle();
        configure(7'd64, 7'd64, 1'b1);
        hold_requests++;
        send_request(REQ_LOAD, 6'd0, '1);
        send_request(REQ_LOAD, 6'd63, '1);
        send_request(REQ_STEP, '0, '0);
        send_request(REQ_STEP, '0, '0);
        send_request(REQ_STEP, '0, '0);

        // Random phases: new settings, then seeded generations mixed with noise.
        while (useful_items < RANDOM_ITEMS)
        begin
            wait_idle();
            idle_level = ($urandom_range(0, 3) == 0) ? 0 : 1;
            case ($urandom_range(0, 9))
                0:       width = SIZE_W'($urandom_range(0, 2));
                1:       width = SIZE_W'($urandom_range(65, 127));
                2, 3:    width = 7'd64;
                4:       width = 7'd3;
                default: width = SIZE_W'($urandom_range(3, 64));
            endcase
            case ($urandom_range(0, 9))
                0:       height = SIZE_W'($urandom_range(0, 2));
                1:       height = SIZE_W'($urandom_range(65, 127));
                2:       height = 7'd64;
                3:       height = 7'd3;
                default: height = SIZE_W'($urandom_range(3, 16));
            endcase
            configure(width, height, 1'($urandom_range(0, 1)));

            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    // Seed a pattern and run it for a few generations.
                    if ($urandom_range(0, 2) != 0)
                    begin
                        send_request(REQ_CLEAR, ROW_IDX_W'($urandom), random_cells());
                        useful_items++;
                    end
                    repeat ($urandom_range(1, used_height))
                    begin
                        row = ROW_IDX_W'($urandom_range(0, used_height - 1));
                        send_request(REQ_LOAD, row, random_cells());
                        useful_items++;
                    end
                    repeat ($urandom_range(1, 4))
                    begin
                        send_request(REQ_STEP, ROW_IDX_W'($urandom), random_cells());
                        useful_items++;
                    end
                end
                else
                begin
                    // Noise: any kind, any row, any contents.
                    repeat ($urandom_range(1, 6))
                    begin
                        kind = KIND_W'($urandom_range(0, 3));
                        row  = ROW_IDX_W'($urandom_range(0, 63));
                        send_request(kind, row, random_cells());
                        if (!(kind == REQ_UNUSED ||
                              (kind == REQ_LOAD && int'(row) >= used_height)))
                        begin
                            useful_items++;
                        end
                    end
                end
            end
        end

        wait_idle();
        repeat (END_CYCLES) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("life_grid_generation_step: match");
        end
        else
        begin
            $display("life_grid_generation_step: mismatch");
        end
        $finish;
    end

endmodule
